>>> hdl/rabs_pkg.sv
package rabs_pkg;

  // fixed field widths
  localparam int COLOR_W = 8;
  localparam int INDEX_W = 19;
  localparam int GRAY_W  = 8;
  localparam int THR_W   = 8;
  localparam int RATE_W  = 9;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  // default sizing
  localparam int FRAME_PIXELS_DEF = 307200;
  localparam int BG_FRAC_BITS_DEF = 8;

  // register reset values
  localparam logic [THR_W-1:0]  DIFF_THRESHOLD_RESET = THR_W'(20);
  localparam logic [RATE_W-1:0] LEARN_RATE_RESET     = RATE_W'(77);

  // gray weights, sum of weights is 1 << GRAY_SHIFT
  localparam int GRAY_SHIFT = 14;
  localparam int GRAY_SUM_W = 22;
  localparam logic [GRAY_SUM_W-1:0] W_BLUE   = GRAY_SUM_W'(1868);
  localparam logic [GRAY_SUM_W-1:0] W_GREEN  = GRAY_SUM_W'(9617);
  localparam logic [GRAY_SUM_W-1:0] W_RED    = GRAY_SUM_W'(4899);
  localparam logic [GRAY_SUM_W-1:0] GRAY_RND = GRAY_SUM_W'(8192);

  // register map, selected by paddr[2]
  typedef enum logic {
    REG_DIFF_THRESHOLD = 1'b0,
    REG_LEARN_RATE     = 1'b1
  } reg_sel_t;

  typedef struct packed {
    logic [THR_W-1:0]  diff_threshold;
    logic [RATE_W-1:0] learn_rate;
  } cfg_t;

  // weighted gray conversion
  function automatic logic [GRAY_W-1:0] to_gray(input logic [COLOR_W-1:0] b,
                                                input logic [COLOR_W-1:0] g,
                                                input logic [COLOR_W-1:0] r);
    logic [GRAY_SUM_W-1:0] sum;
    sum = GRAY_SUM_W'(b) * W_BLUE + GRAY_SUM_W'(g) * W_GREEN
        + GRAY_SUM_W'(r) * W_RED + GRAY_RND;
    return sum[GRAY_SHIFT +: GRAY_W];
  endfunction

endpackage

>>> hdl/rabs_ram.sv
module rabs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  clk,
  we,
  waddr,
  wdata,
  re,
  raddr,
  rdata
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  input  logic             clk;
  input  logic             we;
  input  logic [AW-1:0]    waddr;
  input  logic [WIDTH-1:0] wdata;
  input  logic             re;
  input  logic [AW-1:0]    raddr;
  output logic [WIDTH-1:0] rdata;

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/rabs_regs.sv
module rabs_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rabs_pkg::ADDR_W-1:0]   paddr,
  input  logic [rabs_pkg::DATA_W-1:0]   pwdata,
  output logic [rabs_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output rabs_pkg::cfg_t                cfg
);
  import rabs_pkg::*;

  reg_sel_t sel;
  logic     wr;

  assign sel    = reg_sel_t'(paddr[2]);
  assign wr     = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.diff_threshold <= DIFF_THRESHOLD_RESET;
      cfg.learn_rate     <= LEARN_RATE_RESET;
    end else if (wr) begin
      case (sel)
        REG_DIFF_THRESHOLD: cfg.diff_threshold <= pwdata[THR_W-1:0];
        REG_LEARN_RATE:     cfg.learn_rate     <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (sel)
      REG_DIFF_THRESHOLD: prdata = DATA_W'(cfg.diff_threshold);
      REG_LEARN_RATE:     prdata = DATA_W'(cfg.learn_rate);
      default:            prdata = '0;
    endcase
  end

endmodule

>>> hdl/rabs_pipe.sv
module rabs_pipe #(
  parameter int FRAME_PIXELS = rabs_pkg::FRAME_PIXELS_DEF,
  parameter int BG_FRAC_BITS = rabs_pkg::BG_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  rabs_pkg::cfg_t                 cfg,
  input  logic                           pixel_valid,
  output logic                           pixel_ready,
  input  logic [rabs_pkg::COLOR_W-1:0]   blue,
  input  logic [rabs_pkg::COLOR_W-1:0]   green,
  input  logic [rabs_pkg::COLOR_W-1:0]   red,
  input  logic [rabs_pkg::INDEX_W-1:0]   pixel_index,
  input  logic                           frame_end,
  output logic                           mask_valid,
  input  logic                           mask_ready,
  output logic                           is_background,
  output logic                           frame_done
);
  import rabs_pkg::*;

  localparam int F       = BG_FRAC_BITS;
  localparam int BG_W    = GRAY_W + F;
  localparam int AW      = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int DELTA_W = BG_W + 1;
  localparam int PROD_W  = DELTA_W + RATE_W + 1;
  localparam int STEP_W  = PROD_W - 8;
  localparam int CMP_W   = 32;

  localparam logic [BG_W:0]        HALF = (BG_W + 1)'(1) << (F - 1);
  localparam logic [CMP_W-1:0]     LIMIT = CMP_W'(FRAME_PIXELS);
  localparam logic [GRAY_W-1:0]    GRAY_MAX = '1;
  localparam logic [PROD_W-1:0]    TRUNC_BIAS = PROD_W'(255);

  // handshake and stage flow
  logic v1, v2, v3, v4;
  logic move1, move2, move3, move4;
  logic load1, load2, load3, load4;
  logic hazard, accept;

  // input side
  logic          first_frame;
  logic [AW-1:0] addr_in;
  logic          inr_in;

  // stage 1: gray, address, read issued
  logic [GRAY_W-1:0] gray1;
  logic [AW-1:0]     addr1;
  logic              inr1, first1, fend1;
  logic [BG_W-1:0]   rdata;

  // stage 2: compare done, delta formed
  logic [BG_W-1:0]          bg2;
  logic signed [DELTA_W-1:0] delta2;
  logic [AW-1:0]            addr2;
  logic                     isbg2, fend2;

  // stage 3: product
  logic [BG_W-1:0]          bg3;
  logic signed [PROD_W-1:0] prod3;
  logic [AW-1:0]            addr3;
  logic                     isbg3, fend3;

  // stage 1 combinational
  logic [BG_W-1:0]           bg_s1;
  logic [BG_W:0]             rnd_sum;
  logic [GRAY_W:0]           rnd;
  logic [GRAY_W-1:0]         bg8;
  logic [GRAY_W-1:0]         diff;
  logic                      isbg_next;
  logic signed [DELTA_W-1:0] delta_next;

  // stage 3 combinational
  logic signed [PROD_W-1:0] adj;
  logic signed [STEP_W-1:0] step;
  logic signed [STEP_W:0]   nv_wide;
  logic [BG_W-1:0]          nv;

  assign addr_in = AW'(pixel_index);
  assign inr_in  = CMP_W'(pixel_index) < LIMIT;

  // stage flow, a stage loads when empty or when its word moves on
  assign move4 = v4 && mask_ready;
  assign load4 = !v4 || move4;
  assign move3 = v3 && load4;
  assign load3 = !v3 || move3;
  assign move2 = v2 && load3;
  assign load2 = !v2 || move2;
  assign move1 = v1 && load2;
  assign load1 = !v1 || move1;

  // hold a pixel whose word is still being updated further down
  assign hazard = inr_in && ((v1 && inr1  && addr1 == addr_in) ||
                             (v2 && isbg2 && addr2 == addr_in) ||
                             (v3 && isbg3 && addr3 == addr_in));

  assign pixel_ready = load1 && !hazard;
  assign accept      = pixel_valid && pixel_ready;

  // first frame flag
  always_ff @(posedge clk) begin
    if (rst) begin
      first_frame <= 1'b1;
    end else if (accept && frame_end) begin
      first_frame <= 1'b0;
    end
  end

  // background store
  rabs_ram #(
    .WIDTH (BG_W),
    .DEPTH (FRAME_PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (move3 && isbg3),
    .waddr (addr3),
    .wdata (nv),
    .re    (accept && inr_in),
    .raddr (addr_in),
    .rdata (rdata)
  );

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (load1) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (load1 && accept) begin
      gray1  <= to_gray(blue, green, red);
      addr1  <= addr_in;
      inr1   <= inr_in;
      first1 <= first_frame;
      fend1  <= frame_end;
    end
  end

  // round background, absolute difference, threshold, delta
  always_comb begin
    bg_s1      = first1 ? {gray1, {F{1'b0}}} : rdata;
    rnd_sum    = {1'b0, bg_s1} + HALF;
    rnd        = rnd_sum[BG_W:F];
    bg8        = rnd[GRAY_W] ? GRAY_MAX : rnd[GRAY_W-1:0];
    diff       = (bg8 > gray1) ? bg8 - gray1 : gray1 - bg8;
    isbg_next  = inr1 && (diff <= cfg.diff_threshold);
    delta_next = $signed({1'b0, gray1, {F{1'b0}}}) - $signed({1'b0, bg_s1});
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (load2) begin
      v2 <= move1;
    end
  end

  always_ff @(posedge clk) begin
    if (load2 && move1) begin
      bg2    <= bg_s1;
      delta2 <= delta_next;
      addr2  <= addr1;
      isbg2  <= isbg_next;
      fend2  <= fend1;
    end
  end

  // stage 3 registers, weight times delta
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (load3) begin
      v3 <= move2;
    end
  end

  always_ff @(posedge clk) begin
    if (load3 && move2) begin
      bg3   <= bg2;
      prod3 <= $signed({1'b0, cfg.learn_rate}) * delta2;
      addr3 <= addr2;
      isbg3 <= isbg2;
      fend3 <= fend2;
    end
  end

  // divide by 256 toward zero, add, saturate to the word range
  always_comb begin
    adj     = prod3 + (prod3[PROD_W-1] ? $signed(TRUNC_BIAS) : $signed(PROD_W'(0)));
    step    = adj[PROD_W-1:8];
    nv_wide = $signed({{(STEP_W + 1 - BG_W){1'b0}}, bg3}) + $signed({step[STEP_W-1], step});
    if (nv_wide[STEP_W]) begin
      nv = '0;
    end else if (nv_wide[STEP_W-1:BG_W] != '0) begin
      nv = '1;
    end else begin
      nv = nv_wide[BG_W-1:0];
    end
  end

  // stage 4, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (load4) begin
      v4 <= move3;
    end
  end

  always_ff @(posedge clk) begin
    if (load4 && move3) begin
      is_background <= isbg3;
      frame_done    <= fend3;
    end
  end

  assign mask_valid = v4;

endmodule

>>> hdl/running_average_background_subtract.sv
// path: an accepted pixel passes the stage 1, 2 and 3 registers to the stage 4 output register
// throughput: one pixel per cycle unless mask_ready stalls; a pixel whose index
//   matches one of the up to three pixels still ahead of it waits until that one
//   has written its background word back, as the store is a read-modify-write loop
// reset: synchronous, clears the pipeline valids, rearms first-frame loading and
//   restores diff_threshold = 20 and learn_rate = 77; the store is not cleared
module running_average_background_subtract #(
  parameter int FRAME_PIXELS = rabs_pkg::FRAME_PIXELS_DEF,
  parameter int BG_FRAC_BITS = rabs_pkg::BG_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rabs_pkg::ADDR_W-1:0]    paddr,
  input  logic [rabs_pkg::DATA_W-1:0]    pwdata,
  output logic [rabs_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  input  logic                           pixel_valid,
  output logic                           pixel_ready,
  input  logic [rabs_pkg::COLOR_W-1:0]   blue,
  input  logic [rabs_pkg::COLOR_W-1:0]   green,
  input  logic [rabs_pkg::COLOR_W-1:0]   red,
  input  logic [rabs_pkg::INDEX_W-1:0]   pixel_index,
  input  logic                           frame_end,
  output logic                           mask_valid,
  input  logic                           mask_ready,
  output logic                           is_background,
  output logic                           frame_done
);
  import rabs_pkg::*;

  cfg_t cfg;

  // configuration registers
  rabs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // pixel pipeline with background store
  rabs_pipe #(
    .FRAME_PIXELS (FRAME_PIXELS),
    .BG_FRAC_BITS (BG_FRAC_BITS)
  ) u_pipe (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .pixel_valid   (pixel_valid),
    .pixel_ready   (pixel_ready),
    .blue          (blue),
    .green         (green),
    .red           (red),
    .pixel_index   (pixel_index),
    .frame_end     (frame_end),
    .mask_valid    (mask_valid),
    .mask_ready    (mask_ready),
    .is_background (is_background),
    .frame_done    (frame_done)
  );

endmodule

>>> hdl/rabs_checker.sv
module rabs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [rabs_pkg::ADDR_W-1:0]    paddr,
  input logic [rabs_pkg::DATA_W-1:0]    pwdata,
  input logic [rabs_pkg::DATA_W-1:0]    prdata,
  input logic                           pixel_valid,
  input logic                           pixel_ready,
  input logic                           mask_valid,
  input logic                           mask_ready,
  input logic                           is_background,
  input logic                           frame_done
);
  import rabs_pkg::*;

  logic [2:0] pending;
  logic       in_acc, out_acc;

  assign in_acc  = pixel_valid && pixel_ready;
  assign out_acc = mask_valid && mask_ready;

  // words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(in_acc) - 3'(out_acc);
    end
  end

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !mask_valid)
    else $error("mask_valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    mask_valid && !mask_ready |=> mask_valid && $stable(is_background)
                                  && $stable(frame_done))
    else $error("stalled mask word changed");

  // no result without a pixel, never more than four in flight
  a_count: assert property (@(posedge clk) disable iff (rst)
    (!mask_valid || pending != 3'd0) && pending <= 3'd4)
    else $error("mask word count mismatch");

  // an empty block takes a pixel
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    pending == 3'd0 |-> pixel_ready)
    else $error("idle block not ready");

  // learn_rate reads back what was written
  a_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr[2]) ##1 (!pwrite && paddr[2])
      |-> prdata == DATA_W'($past(pwdata[RATE_W-1:0])))
    else $error("learn_rate readback mismatch");

endmodule

bind running_average_background_subtract rabs_checker u_rabs_checker (.*);
